// File: rtl/core/nmgga_pkg.sv
// ----------------------------------------------------------------------------
// nmgga_pkg
// Shared types and constants for the NMEA GGA sentence capture block.
// ----------------------------------------------------------------------------
package nmgga_pkg;

    typedef enum logic [1:0] {
        OP_RECV     = 2'd0,
        OP_RD_BYTE  = 2'd1,
        OP_RD_COMMA = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_STORE = 2'd1,
        SRC_COMMA = 2'd2
    } read_src_t;

    localparam logic [7:0]  CH_START  = 8'h24;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [23:0] TAG_RESET = 24'h474741;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    // Item classified by the front end, waiting on its read data.
    typedef struct packed {
        logic       byte_stored;
        logic [7:0] store_position;
        logic       comma_recorded;
        logic [4:0] comma_ordinal;
        logic       capturing;
        logic       overflowed;
        logic       read_valid;
        read_src_t  read_src;
    } entry_t;

    // Finished result beat.
    typedef struct packed {
        logic       byte_stored;
        logic [7:0] store_position;
        logic       comma_recorded;
        logic [4:0] comma_ordinal;
        logic       capturing;
        logic       overflowed;
        logic [7:0] read_data;
        logic       read_valid;
    } result_t;

endpackage

// File: rtl/core/nmgga_ram.sv
// ----------------------------------------------------------------------------
// nmgga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmgga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/nmgga_front.sv
// ----------------------------------------------------------------------------
// nmgga_front
// Accepts beats, tracks tag window and capture state, issues memory writes
// and reads, and registers the classified item for the result queue.
// ----------------------------------------------------------------------------
module nmgga_front import nmgga_pkg::*; #(
    parameter int BUFFER_DEPTH = 256,
    parameter int COMMA_SLOTS  = 32,
    parameter int AW           = $clog2(BUFFER_DEPTH),
    parameter int CW           = $clog2(COMMA_SLOTS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [23:0]   cfg_data,
    input  logic          accept,
    input  logic [1:0]    opcode,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    read_address,
    input  logic [4:0]    comma_slot,
    output logic          store_we,
    output logic [AW-1:0] store_waddr,
    output logic [7:0]    store_wdata,
    output logic [AW-1:0] store_raddr,
    output logic          comma_we,
    output logic [CW-1:0] comma_waddr,
    output logic [7:0]    comma_wdata,
    output logic [CW-1:0] comma_raddr,
    output logic          s1_valid,
    output entry_t        s1_entry
);

    localparam logic [AW:0] WI_FULL = (AW+1)'(BUFFER_DEPTH);
    localparam logic [CW:0] CC_FULL = (CW+1)'(COMMA_SLOTS);

    logic [23:0] tag_reg;
    logic [23:0] win_reg, win_next;
    logic        cap_reg, cap_next;
    logic [AW:0] wi_reg, wi_next;
    logic [CW:0] cc_reg, cc_next;
    logic        ovf_reg, ovf_next;
    logic        s1_valid_reg;
    entry_t      s1_reg, s1_next;
    opcode_t     op;

    assign op = opcode_t'(opcode);

    always_comb
    begin
        win_next    = win_reg;
        cap_next    = cap_reg;
        wi_next     = wi_reg;
        cc_next     = cc_reg;
        ovf_next    = ovf_reg;
        store_we    = 1'b0;
        comma_we    = 1'b0;
        s1_next     = '0;
        s1_next.read_src = SRC_NONE;

        unique case (op)
            OP_RECV:
            begin
                if (rx_byte == CH_START)
                begin
                    wi_next  = '0;
                    cc_next  = '0;
                    ovf_next = 1'b0;
                    cap_next = 1'b0;
                end
                else if (cap_reg)
                begin
                    if (wi_reg < WI_FULL)
                    begin
                        if (rx_byte == CH_COMMA && cc_reg < CC_FULL)
                        begin
                            comma_we               = accept;
                            s1_next.comma_recorded = 1'b1;
                            s1_next.comma_ordinal  = 5'(cc_reg[CW-1:0]);
                            cc_next                = cc_reg + 1'b1;
                        end
                        store_we               = accept;
                        s1_next.byte_stored    = 1'b1;
                        s1_next.store_position = 8'(wi_reg[AW-1:0]);
                        wi_next                = wi_reg + 1'b1;
                    end
                    if (wi_next >= WI_FULL)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (win_reg == tag_reg)
                begin
                    cap_next = 1'b1;
                    win_next = '0;
                end
                else
                begin
                    win_next = {win_reg[15:0], rx_byte};
                end
            end
            OP_RD_BYTE:
            begin
                s1_next.read_src   = SRC_STORE;
                s1_next.read_valid = 9'(read_address) < 9'(wi_reg);
            end
            OP_RD_COMMA:
            begin
                s1_next.read_src   = SRC_COMMA;
                s1_next.read_valid = 6'(comma_slot) < 6'(cc_reg);
            end
            default:
            begin
                s1_next.read_src = SRC_NONE;
            end
        endcase

        s1_next.capturing  = cap_next;
        s1_next.overflowed = ovf_next;
    end

    assign store_waddr = wi_reg[AW-1:0];
    assign store_wdata = rx_byte;
    assign store_raddr = read_address[AW-1:0];
    assign comma_waddr = cc_reg[CW-1:0];
    assign comma_wdata = 8'(wi_reg[AW-1:0]);
    assign comma_raddr = comma_slot[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg      <= TAG_RESET;
            win_reg      <= '0;
            cap_reg      <= 1'b0;
            wi_reg       <= '0;
            cc_reg       <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tag_reg <= cfg_data;
            end
            if (accept)
            begin
                win_reg <= win_next;
                cap_reg <= cap_next;
                wi_reg  <= wi_next;
                cc_reg  <= cc_next;
                ovf_reg <= ovf_next;
            end
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_entry = s1_reg;

endmodule

// File: rtl/core/nmgga_queue.sv
// ----------------------------------------------------------------------------
// nmgga_queue
// Back end: merges read data into classified items and holds finished
// results until they are popped.
// ----------------------------------------------------------------------------
module nmgga_queue import nmgga_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  entry_t     in_entry,
    input  logic [7:0] store_rdata,
    input  logic [7:0] comma_rdata,
    input  logic       pop,
    output result_t    head,
    output logic [QAW:0] count,
    output logic       empty
);

    result_t          slots_reg [QUEUE_DEPTH];
    result_t          res;
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             do_pop;

    always_comb
    begin
        res.byte_stored    = in_entry.byte_stored;
        res.store_position = in_entry.store_position;
        res.comma_recorded = in_entry.comma_recorded;
        res.comma_ordinal  = in_entry.comma_ordinal;
        res.capturing      = in_entry.capturing;
        res.overflowed     = in_entry.overflowed;
        res.read_valid     = in_entry.read_valid;
        res.read_data      = '0;
        if (in_entry.read_valid)
        begin
            unique case (in_entry.read_src)
                SRC_STORE: res.read_data = store_rdata;
                SRC_COMMA: res.read_data = comma_rdata;
                default:   res.read_data = '0;
            endcase
        end
    end

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= res;
        end
    end

    assign head  = slots_reg[rd_ptr_reg];
    assign count = count_reg;
    assign empty = (count_reg == '0);

endmodule

// File: rtl/core/nmea_gga_sentence_capture.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_capture
// Captures NMEA sentences with a configured tag into a byte store and a
// comma position table; answers read beats from both.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------
//  input    | push / full      | opcode, rx_byte, read_address, comma_slot
//  result   | pop / empty      | byte_stored .. read_valid
//  config   | cfg_we           | cfg_data (sentence tag)
//
//  One beat per cycle sustained while full is low. A taken beat's state update
//  and memory read are registered first; the staged item and read data are then
//  merged and written into the result queue, whose head drives the result ports.
//  Four-entry result queue; full rises when queued plus in-flight reach it.
//  Reset clears tag window, capture state, counts and queue; store and comma
//  table contents are only reported as valid read data after being written.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_capture import nmgga_pkg::*; #(
    parameter int BUFFER_DEPTH = 256,
    parameter int COMMA_SLOTS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  read_address,
    input  logic [4:0]  comma_slot,
    output logic        empty,
    input  logic        pop,
    output logic        byte_stored,
    output logic [7:0]  store_position,
    output logic        comma_recorded,
    output logic [4:0]  comma_ordinal,
    output logic        capturing,
    output logic        overflowed,
    output logic [7:0]  read_data,
    output logic        read_valid
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(COMMA_SLOTS);

    logic          accept;
    logic          store_we, comma_we;
    logic [AW-1:0] store_waddr, store_raddr;
    logic [CW-1:0] comma_waddr, comma_raddr;
    logic [7:0]    store_wdata, comma_wdata, store_rdata, comma_rdata;
    logic          s1_valid;
    entry_t        s1_entry;
    result_t       head;
    logic [QAW:0]  q_count;
    logic [QAW+1:0] q_level;

    assign q_level = (QAW+2)'(q_count) + (QAW+2)'(s1_valid);
    assign full    = q_level >= (QAW+2)'(QUEUE_DEPTH);
    assign accept  = push && !full;

    nmgga_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .COMMA_SLOTS  (COMMA_SLOTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .read_address (read_address),
        .comma_slot   (comma_slot),
        .store_we     (store_we),
        .store_waddr  (store_waddr),
        .store_wdata  (store_wdata),
        .store_raddr  (store_raddr),
        .comma_we     (comma_we),
        .comma_waddr  (comma_waddr),
        .comma_wdata  (comma_wdata),
        .comma_raddr  (comma_raddr),
        .s1_valid     (s1_valid),
        .s1_entry     (s1_entry)
    );

    nmgga_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    nmgga_ram #(
        .WIDTH (8),
        .DEPTH (COMMA_SLOTS)
    ) u_commas (
        .clk   (clk),
        .we    (comma_we),
        .waddr (comma_waddr),
        .wdata (comma_wdata),
        .raddr (comma_raddr),
        .rdata (comma_rdata)
    );

    nmgga_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (s1_valid),
        .in_entry    (s1_entry),
        .store_rdata (store_rdata),
        .comma_rdata (comma_rdata),
        .pop         (pop),
        .head        (head),
        .count       (q_count),
        .empty       (empty)
    );

    assign byte_stored    = head.byte_stored;
    assign store_position = head.store_position;
    assign comma_recorded = head.comma_recorded;
    assign comma_ordinal  = head.comma_ordinal;
    assign capturing      = head.capturing;
    assign overflowed     = head.overflowed;
    assign read_data      = head.read_data;
    assign read_valid     = head.read_valid;

`ifndef NO_ASSERTIONS
    a_no_queue_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid && q_count == (QAW+1)'(QUEUE_DEPTH)))
        else $error("result queue overrun");

    a_accept_flows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid)
        else $error("accepted beat not staged");

    a_staged_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |=> !empty)
        else $error("staged beat did not reach queue");

    a_store_needs_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_stored) |-> capturing)
        else $error("byte stored outside capture");

    a_comma_is_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && comma_recorded) |-> byte_stored)
        else $error("comma recorded but not stored");
`endif

endmodule
